// File: src/afd_pkg.sv
`default_nettype none

package afd_pkg;

    // Parser phase
    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_LEN_HI = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_TYPE   = 3'd3,
        PH_BODY   = 3'd4,
        PH_CHECK  = 3'd5
    } t_phase;

    // End status codes
    localparam logic [1:0] ST_GOOD     = 2'd0;
    localparam logic [1:0] ST_BAD_SUM  = 2'd1;
    localparam logic [1:0] ST_UNKNOWN  = 2'd2;
    localparam logic [1:0] ST_NO_DELIM = 2'd3;

    localparam int          NUM_KINDS    = 5;
    localparam logic [2:0]  KIND_UNKNOWN = 3'd5;
    localparam logic [7:0]  SUM_GOOD     = 8'hFF;

    // Configuration register indexes
    localparam logic [2:0] CFG_START_DELIM   = 3'd0;
    localparam logic [2:0] CFG_TX_STATUS     = 3'd1;
    localparam logic [2:0] CFG_ZB_TX_STATUS  = 3'd2;
    localparam logic [2:0] CFG_RX_LONG_ADDR  = 3'd3;
    localparam logic [2:0] CFG_RX_SHORT_ADDR = 3'd4;
    localparam logic [2:0] CFG_ZB_RX         = 3'd5;

    // Configuration as seen by the parser
    typedef struct packed {
        logic [7:0]                 start_delim;
        logic [NUM_KINDS-1:0][7:0]  type_code;
    } t_cfg;

    // One result word
    typedef struct packed {
        logic        is_last;
        logic [7:0]  body_byte;
        logic [15:0] body_index;
        logic [2:0]  frame_kind;
        logic [1:0]  end_status;
    } t_result;

endpackage

`default_nettype wire

// File: src/afd_core.sv
`default_nettype none

module afd_core import afd_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_step,
    input  wire logic [7:0] i_byte,
    input  wire t_cfg    i_cfg,
    output logic         o_has_result,
    output t_result      o_result
);

    t_phase      r_phase,  n_phase;
    logic [15:0] r_pos,    n_pos;
    logic [15:0] r_len,    n_len;
    logic [7:0]  r_sum,    n_sum;
    logic [2:0]  r_kind,   n_kind;

    logic [2:0]  match_kind;
    logic [7:0]  sum_next;
    logic [15:0] pos_next;

    // Type lookup, lowest matching slot wins
    always_comb begin
        match_kind = KIND_UNKNOWN;
        for (int k = NUM_KINDS - 1; k >= 0; k--) begin
            if (i_cfg.type_code[k] == i_byte) begin
                match_kind = 3'(k);
            end
        end
    end

    assign sum_next = r_sum + i_byte;
    assign pos_next = r_pos + 16'd1;

    // Next state and result
    always_comb begin
        n_phase      = r_phase;
        n_pos        = r_pos;
        n_len        = r_len;
        n_sum        = r_sum;
        n_kind       = r_kind;
        o_has_result = 1'b0;
        o_result     = '0;

        case (r_phase)
            PH_LEN_HI: begin
                n_len   = {i_byte, 8'h00};
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_len   = {r_len[15:8], i_byte};
                n_phase = PH_TYPE;
            end
            PH_TYPE: begin
                o_has_result = 1'b1;
                if (match_kind == KIND_UNKNOWN) begin
                    o_result.is_last    = 1'b1;
                    o_result.frame_kind = KIND_UNKNOWN;
                    o_result.end_status = ST_UNKNOWN;
                    n_phase = PH_HUNT;
                    n_pos   = '0;
                    n_len   = '0;
                    n_sum   = '0;
                    n_kind  = KIND_UNKNOWN;
                end else if (r_len == 16'd0) begin
                    // empty frame closes bad on its type byte
                    o_result.is_last    = 1'b1;
                    o_result.frame_kind = match_kind;
                    o_result.end_status = ST_BAD_SUM;
                    n_phase = PH_HUNT;
                    n_pos   = '0;
                    n_len   = '0;
                    n_sum   = '0;
                    n_kind  = KIND_UNKNOWN;
                end else begin
                    o_result.body_byte  = i_byte;
                    o_result.frame_kind = match_kind;
                    o_result.end_status = ST_GOOD;
                    n_sum   = sum_next;
                    n_kind  = match_kind;
                    n_pos   = 16'd1;
                    n_phase = (r_len == 16'd1) ? PH_CHECK : PH_BODY;
                end
            end
            PH_BODY: begin
                o_has_result        = 1'b1;
                o_result.body_byte  = i_byte;
                o_result.body_index = r_pos;
                o_result.frame_kind = r_kind;
                o_result.end_status = ST_GOOD;
                n_sum = sum_next;
                n_pos = pos_next;
                if (pos_next == r_len) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                o_has_result        = 1'b1;
                o_result.is_last    = 1'b1;
                o_result.body_index = r_len;
                o_result.frame_kind = r_kind;
                o_result.end_status = (sum_next == SUM_GOOD) ? ST_GOOD : ST_BAD_SUM;
                n_phase = PH_HUNT;
                n_pos   = '0;
                n_len   = '0;
                n_sum   = '0;
                n_kind  = KIND_UNKNOWN;
            end
            default: begin
                // hunting; unused codes land here too
                n_pos  = '0;
                n_len  = '0;
                n_sum  = '0;
                n_kind = KIND_UNKNOWN;
                if (i_byte == i_cfg.start_delim) begin
                    n_phase = PH_LEN_HI;
                end else begin
                    o_has_result        = 1'b1;
                    o_result.is_last    = 1'b1;
                    o_result.frame_kind = KIND_UNKNOWN;
                    o_result.end_status = ST_NO_DELIM;
                    n_phase = PH_HUNT;
                end
            end
        endcase
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_pos   <= '0;
            r_len   <= '0;
            r_sum   <= '0;
            r_kind  <= KIND_UNKNOWN;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_sum   <= n_sum;
            r_kind  <= n_kind;
        end
    end

endmodule

`default_nettype wire

// File: src/api_frame_deframer.sv
// Channel | Direction | Handshake                  | Word
// --------+-----------+----------------------------+---------------------------------
// in      | input     | i_in_valid / o_in_ready    | i_rx_byte
// out     | output    | o_out_valid / i_out_ready  | o_is_last, o_body_byte,
//         |           |                            | o_body_index, o_frame_kind,
//         |           |                            | o_end_status
// cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One byte per cycle sustained while the output is not stalled; a byte is
// captured in the input register when taken, and the parser logic loads its
// result into the result register when that byte advances.
// Bytes that produce no result (delimiter, length) never wait on the output.
// An output stall parks the next byte in the input register; a second byte is
// then refused until the result word is taken.
// Reset (synchronous, active low) re-arms delimiter hunting and loads the
// default delimiter and type codes; the cfg port is always ready.
`default_nettype none

module api_frame_deframer import afd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input bytes
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_rx_byte,
    // results
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_is_last,
    output logic [7:0]       o_body_byte,
    output logic [15:0]      o_body_index,
    output logic [2:0]       o_frame_kind,
    output logic [1:0]       o_end_status,
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    t_cfg       r_cfg;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;

    logic       core_has_result;
    t_result    core_result;
    logic       out_free;
    logic       advance;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_delim  <= 8'h7E;
            r_cfg.type_code[0] <= 8'h89;
            r_cfg.type_code[1] <= 8'h8B;
            r_cfg.type_code[2] <= 8'h80;
            r_cfg.type_code[3] <= 8'h81;
            r_cfg.type_code[4] <= 8'h90;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_START_DELIM:   r_cfg.start_delim  <= i_cfg_data;
                CFG_TX_STATUS:     r_cfg.type_code[0] <= i_cfg_data;
                CFG_ZB_TX_STATUS:  r_cfg.type_code[1] <= i_cfg_data;
                CFG_RX_LONG_ADDR:  r_cfg.type_code[2] <= i_cfg_data;
                CFG_RX_SHORT_ADDR: r_cfg.type_code[3] <= i_cfg_data;
                CFG_ZB_RX:         r_cfg.type_code[4] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Flow control: the parsed byte moves on when its result has room or it makes no result
    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && (out_free || !core_has_result);
    assign o_in_ready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    afd_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_byte       (r_in_byte),
        .i_cfg        (r_cfg),
        .o_has_result (core_has_result),
        .o_result     (core_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && core_has_result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && core_has_result) begin
            r_out <= core_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_is_last    = r_out.is_last;
    assign o_body_byte  = r_out.body_byte;
    assign o_body_index = r_out.body_index;
    assign o_frame_kind = r_out.frame_kind;
    assign o_end_status = r_out.end_status;

    // Body words always belong to a known type and carry good status
    a_body_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.is_last |->
            r_out.end_status == ST_GOOD && r_out.frame_kind != KIND_UNKNOWN)
        else $error("body word with bad status or unknown kind");

    // Unknown-type and missing-delimiter ends carry the unknown kind, index 0
    a_unknown_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.end_status == ST_UNKNOWN
                        || r_out.end_status == ST_NO_DELIM) |->
            r_out.is_last && r_out.frame_kind == KIND_UNKNOWN
            && r_out.body_index == 16'd0 && r_out.body_byte == 8'd0)
        else $error("malformed unknown or stray end word");

    // A held byte in the input register is not overwritten
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_byte))
        else $error("input register lost a byte");

    // A result is only loaded when the result register has room
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && core_has_result |-> out_free)
        else $error("result register overrun");

endmodule

`default_nettype wire
